// ===== src/scd_pkg.sv =====
// scd_pkg.sv - shared types and constants of the sensor command decoder.
// Holds the command and result word layouts, the command codes and the gain lookup.
// No dependencies.
`default_nettype none

package scd_pkg;

    // Input word: one host command frame
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] func;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
        logic [7:0] byte_count;
    } cmd_word_t;

    // Output word: one result of a command
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  word_index;
        logic [31:0] word_data;
        logic [7:0]  frame_count;
        logic        last;
    } res_word_t;

    // Field patch applied while the table is streamed out
    typedef enum logic [1:0] {
        PATCH_NONE,
        PATCH_POWER_SAVE,
        PATCH_ADC,
        PATCH_PGA
    } patch_t;

    localparam int TABLE_WORDS = 8;

    // Result actions
    localparam logic [2:0] ACT_TABLE_WORD  = 3'd0;
    localparam logic [2:0] ACT_EXPOSURE    = 3'd1;
    localparam logic [2:0] ACT_IMAGE_DUMP  = 3'd2;
    localparam logic [2:0] ACT_TEMPERATURE = 3'd3;
    localparam logic [2:0] ACT_REJECT      = 3'd4;

    // Command groups
    localparam logic [7:0] HDR_EXPOSURE = 8'hAA;
    localparam logic [7:0] HDR_CONFIG   = 8'hBB;
    localparam logic [7:0] HDR_DATA     = 8'hCC;

    // Sub-commands of the exposure group
    localparam logic [7:0] FN_SET_FRAMES   = 8'hFF;
    localparam logic [7:0] FN_SET_EXPOSURE = 8'h00;
    localparam logic [7:0] FN_START        = 8'h01;

    // Sub-commands of the sensor config group
    localparam logic [7:0] FN_DEFAULT    = 8'h00;
    localparam logic [7:0] FN_POWER_SAVE = 8'hDD;
    localparam logic [7:0] FN_ADC_GAIN   = 8'hEE;
    localparam logic [7:0] FN_PGA_GAIN   = 8'hFF;

    // Sub-commands of the data request group
    localparam logic [7:0] FN_IMAGE_DUMP  = 8'h00;
    localparam logic [7:0] FN_TEMPERATURE = 8'h01;

    localparam logic [7:0] FRAME_LEN = 8'd4;
    localparam logic [7:0] ADC_MAX   = 8'd23;
    localparam logic [7:0] PGA_MAX   = 8'd9;

    // Table word positions with patched fields
    localparam logic [2:0] IDX_PGA_TOP    = 3'd2;
    localparam logic [2:0] IDX_PGA_BOT    = 3'd3;
    localparam logic [2:0] IDX_ADC        = 3'd4;
    localparam logic [2:0] IDX_POWER_SAVE = 3'd7;
    localparam logic [2:0] IDX_LAST       = 3'd7;

    localparam logic [31:0] POWER_SAVE_BIT = 32'h0010_0000;
    localparam logic [11:0] TRAIN_WORD     = 12'hC93;

    // ms * 1000 / 56 = ms * 125 / 7, taken as (ms * 125 * ceil(2^18 / 7)) >> 18;
    // exact for every 8-bit ms
    localparam logic [22:0] LINE_RECIP = 23'd4681250;
    localparam int          LINE_SHIFT = 18;

    localparam logic [31:0] TABLE_RESET [TABLE_WORDS] = '{
        32'd4042080374, 32'd3892444775, 32'd13,         32'd2816899456,
        32'd2823196561, 32'd2382365633, 32'd1335122926, 32'd3232648434
    };

    // Gain code: the gain index with its five bits reversed
    function automatic logic [4:0] gain_lut(input logic [4:0] idx);
        logic [4:0] code;
        for (int i = 0; i < 5; i++) begin
            code[i] = idx[4 - i];
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== src/sensor_command_decoder.sv =====
// sensor_command_decoder.sv - decodes host command frames into sensor table words and requests.
// Depends on scd_pkg for word layouts, command codes and the gain lookup.
//
//  channel | ports                         | direction | word
//  --------+-------------------------------+-----------+------------------------------
//  command | s_valid s_ready s_data        | in        | cmd_word_t, one frame
//  result  | m_valid m_ready m_data        | out       | res_word_t, one result
//  config  | cfg_valid cfg_ready cfg_index | in        | table word index and cfg_data
//
//  A command is decoded in the cycle it is accepted and parked in a one-deep job
//  register; its first result moves to the output register once that is free.
//  Single-result commands sustain one word per cycle unless the output stalls;
//  a sensor config command streams its eight table words one per cycle through
//  the job counter, unless stalled, occupying the job register throughout.
//  A new command is accepted in the cycle its predecessor's last word moves
//  to the output register. Reset restores the table words, frame count 1 and
//  exposure 2 ms. A stalled output holds the job and, once it is full, s_ready.
`default_nettype none

module sensor_command_decoder (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire scd_pkg::cmd_word_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output scd_pkg::res_word_t     m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import scd_pkg::*;

    // Configuration table and command state
    logic [31:0] table_reg [TABLE_WORDS];
    logic [7:0]  frames_reg, frames_next;
    logic [7:0]  exposure_reg, exposure_next;

    // Job register: the accepted command still producing results
    logic        job_valid_reg, job_valid_next;
    logic        job_table_reg, job_table_next;
    logic [2:0]  job_action_reg, job_action_next;
    logic [31:0] job_data_reg, job_data_next;
    logic [7:0]  job_frames_reg, job_frames_next;
    patch_t      job_patch_reg, job_patch_next;
    logic [4:0]  job_lut_a_reg, job_lut_a_next;
    logic [4:0]  job_lut_b_reg, job_lut_b_next;
    logic [2:0]  idx_reg, idx_next;

    // Output register
    logic        m_valid_reg, m_valid_next;
    res_word_t   m_data_reg, m_data_next;

    // Decode results
    logic        dec_has_result;
    logic        dec_table;
    logic [2:0]  dec_action;
    logic [31:0] dec_data;
    logic [7:0]  dec_frames;
    patch_t      dec_patch;
    logic [30:0] lines_prod;
    logic [12:0] lines;

    logic        out_free;
    logic        job_step;
    logic        job_last;
    logic        s_accept;
    logic [31:0] tbl_word;
    res_word_t   cur_res;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Handshake: the job slot frees as its last word enters the output register
    assign out_free = !m_valid_reg || m_ready;
    assign job_step = job_valid_reg && out_free;
    assign job_last = !job_table_reg || (idx_reg == IDX_LAST);
    assign s_ready  = !job_valid_reg || (job_step && job_last);
    assign s_accept = s_valid && s_ready;

    // Exposure in line times from the current exposure register
    assign lines_prod = 31'(exposure_reg) * 31'(LINE_RECIP);
    assign lines      = lines_prod[LINE_SHIFT +: 13];

    // Decode the incoming frame and update the command state
    always_comb begin
        dec_has_result = 1'b0;
        dec_table      = 1'b0;
        dec_action     = ACT_REJECT;
        dec_data       = '0;
        dec_frames     = '0;
        dec_patch      = PATCH_NONE;
        frames_next    = frames_reg;
        exposure_next  = exposure_reg;
        if (s_data.byte_count == FRAME_LEN) begin
            case (s_data.header)
                HDR_EXPOSURE: begin
                    case (s_data.func)
                        FN_SET_FRAMES:   frames_next   = s_data.arg_a;
                        FN_SET_EXPOSURE: exposure_next = s_data.arg_a;
                        FN_START: begin
                            dec_has_result = 1'b1;
                            dec_action     = ACT_EXPOSURE;
                            dec_data       = {4'd0, TRAIN_WORD, 3'd0, lines};
                            dec_frames     = frames_reg;
                        end
                        default: ;
                    endcase
                end
                HDR_CONFIG: begin
                    case (s_data.func)
                        FN_DEFAULT: begin
                            dec_has_result = 1'b1;
                            dec_table      = 1'b1;
                        end
                        FN_POWER_SAVE: begin
                            dec_has_result = 1'b1;
                            dec_table      = 1'b1;
                            dec_patch      = PATCH_POWER_SAVE;
                        end
                        FN_ADC_GAIN: begin
                            dec_has_result = 1'b1;
                            if (s_data.arg_b <= ADC_MAX) begin
                                dec_table = 1'b1;
                                dec_patch = PATCH_ADC;
                            end
                        end
                        FN_PGA_GAIN: begin
                            dec_has_result = 1'b1;
                            if (s_data.arg_a <= PGA_MAX && s_data.arg_b <= PGA_MAX) begin
                                dec_table = 1'b1;
                                dec_patch = PATCH_PGA;
                            end
                        end
                        default: ;
                    endcase
                end
                HDR_DATA: begin
                    case (s_data.func)
                        FN_IMAGE_DUMP: begin
                            dec_has_result = 1'b1;
                            dec_action     = ACT_IMAGE_DUMP;
                        end
                        FN_TEMPERATURE: begin
                            dec_has_result = 1'b1;
                            dec_action     = ACT_TEMPERATURE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        // hold state unless a frame is actually taken
        if (!s_accept) begin
            frames_next   = frames_reg;
            exposure_next = exposure_reg;
        end
    end

    // Patch the table word at the job counter
    always_comb begin
        tbl_word = table_reg[idx_reg];
        case (job_patch_reg)
            PATCH_POWER_SAVE: begin
                if (idx_reg == IDX_POWER_SAVE) begin
                    tbl_word = tbl_word | POWER_SAVE_BIT;
                end
            end
            PATCH_ADC: begin
                if (idx_reg == IDX_ADC) begin
                    tbl_word = {tbl_word[31:6], 1'b0, job_lut_b_reg};
                end
            end
            PATCH_PGA: begin
                if (idx_reg == IDX_PGA_TOP) begin
                    tbl_word = tbl_word | (32'(job_lut_a_reg) << 7)
                             | (32'(job_lut_b_reg[2:0]) << 29);
                end
                if (idx_reg == IDX_PGA_BOT) begin
                    tbl_word = tbl_word | 32'(job_lut_b_reg[4:3]);
                end
            end
            default: ;
        endcase
    end

    // Current result of the job
    always_comb begin
        if (job_table_reg) begin
            cur_res.action      = ACT_TABLE_WORD;
            cur_res.word_index  = idx_reg;
            cur_res.word_data   = tbl_word;
            cur_res.frame_count = '0;
            cur_res.last        = (idx_reg == IDX_LAST);
        end else begin
            cur_res.action      = job_action_reg;
            cur_res.word_index  = '0;
            cur_res.word_data   = job_data_reg;
            cur_res.frame_count = job_frames_reg;
            cur_res.last        = 1'b1;
        end
    end

    // Job and output register next state
    always_comb begin
        job_valid_next  = job_valid_reg;
        job_table_next  = job_table_reg;
        job_action_next = job_action_reg;
        job_data_next   = job_data_reg;
        job_frames_next = job_frames_reg;
        job_patch_next  = job_patch_reg;
        job_lut_a_next  = job_lut_a_reg;
        job_lut_b_next  = job_lut_b_reg;
        idx_next        = idx_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (job_step) begin
            // advance: move one result into the output register
            m_valid_next = 1'b1;
            m_data_next  = cur_res;
            if (job_last) begin
                job_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_accept && dec_has_result) begin
            job_valid_next  = 1'b1;
            job_table_next  = dec_table;
            job_action_next = dec_action;
            job_data_next   = dec_data;
            job_frames_next = dec_frames;
            job_patch_next  = dec_patch;
            job_lut_a_next  = gain_lut(s_data.arg_a[4:0]);
            job_lut_b_next  = gain_lut(s_data.arg_b[4:0]);
            idx_next        = '0;
        end
    end

    // Control state and configuration table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            frames_reg    <= 8'd1;
            exposure_reg  <= 8'd2;
            for (int i = 0; i < TABLE_WORDS; i++) begin
                table_reg[i] <= TABLE_RESET[i];
            end
        end else begin
            job_valid_reg <= job_valid_next;
            m_valid_reg   <= m_valid_next;
            frames_reg    <= frames_next;
            exposure_reg  <= exposure_next;
            // drop writes beyond the table
            if (cfg_valid && cfg_ready && cfg_index < 8'(TABLE_WORDS)) begin
                table_reg[cfg_index[2:0]] <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        job_table_reg  <= job_table_next;
        job_action_reg <= job_action_next;
        job_data_reg   <= job_data_next;
        job_frames_reg <= job_frames_next;
        job_patch_reg  <= job_patch_next;
        job_lut_a_reg  <= job_lut_a_next;
        job_lut_b_reg  <= job_lut_b_next;
        idx_reg        <= idx_next;
        m_data_reg     <= m_data_next;
    end

    // A command is taken alongside a busy job only when that job is on its last word
    a_accept_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && job_valid_reg) |-> (job_last && out_free))
        else $error("command accepted while job still has words to send");

    // Only table words continue past a result; others are always last
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.action != ACT_TABLE_WORD) |-> m_data_reg.last)
        else $error("non-table result without last");

    // Last marks exactly the final table word
    a_table_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.action == ACT_TABLE_WORD)
            |-> (m_data_reg.last == (m_data_reg.word_index == IDX_LAST)))
        else $error("table last flag does not match word index");

    // Table words stream without gaps and in order
    a_table_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && m_data_reg.action == ACT_TABLE_WORD && !m_data_reg.last)
            |=> (m_valid_reg && m_data_reg.action == ACT_TABLE_WORD
                 && m_data_reg.word_index == 3'($past(m_data_reg.word_index) + 3'd1)))
        else $error("table word stream broken");

endmodule

`default_nettype wire

// ===== bench/tb_sensor_command_decoder.sv =====
// tb_sensor_command_decoder.sv - self-checking bench for the sensor command decoder.
// Holds a result scoreboard with its own decoder model, handshake drivers and the top module.
// Depends on scd_pkg for the command and result word types and the command codes.

import scd_pkg::*;

class decoder_scoreboard;
    logic [31:0] table_regs [8];
    logic [31:0] patched [8];
    logic [7:0]  frames_req;
    logic [7:0]  exposure_ms;
    res_word_t   expected_results [$];
    int unsigned errors;
    int unsigned commands;
    int unsigned checked;
    int unsigned report_limit;

    function new();
        table_regs[0] = 32'd4042080374;
        table_regs[1] = 32'd3892444775;
        table_regs[2] = 32'd13;
        table_regs[3] = 32'd2816899456;
        table_regs[4] = 32'd2823196561;
        table_regs[5] = 32'd2382365633;
        table_regs[6] = 32'd1335122926;
        table_regs[7] = 32'd3232648434;
        frames_req   = 8'd1;
        exposure_ms  = 8'd2;
        errors       = 0;
        commands     = 0;
        checked      = 0;
        report_limit = 10;
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
        if (idx < 8)
            table_regs[idx[2:0]] = val;
    endfunction

    // Gain code: low five bits of the index in reverse order
    function logic [4:0] gain_code(logic [7:0] idx);
        return {idx[0], idx[1], idx[2], idx[3], idx[4]};
    endfunction

    function void push_word(logic [2:0] action, logic [2:0] index, logic [31:0] data,
                            logic [7:0] frames, logic last);
        res_word_t r;
        r.action      = action;
        r.word_index  = index;
        r.word_data   = data;
        r.frame_count = frames;
        r.last        = last;
        expected_results.push_back(r);
    endfunction

    function void push_table();
        for (int i = 0; i < 8; i++)
            push_word(ACT_TABLE_WORD, i[2:0], patched[i], 8'd0, i == 7);
    endfunction

    function void note_command(cmd_word_t c);
        logic [4:0]  top;
        logic [4:0]  bot;
        logic [31:0] lines;
        commands++;
        if (c.byte_count != FRAME_LEN)
            return;
        foreach (patched[i])
            patched[i] = table_regs[i];
        case (c.header)
            HDR_EXPOSURE: begin
                case (c.func)
                    FN_SET_FRAMES:   frames_req = c.arg_a;
                    FN_SET_EXPOSURE: exposure_ms = c.arg_a;
                    FN_START: begin
                        lines = ({24'd0, exposure_ms} * 32'd1000) / 32'd56;
                        push_word(ACT_EXPOSURE, 3'd0, {4'h0, TRAIN_WORD, lines[15:0]},
                                  frames_req, 1'b1);
                    end
                    default: ;
                endcase
            end
            HDR_CONFIG: begin
                case (c.func)
                    FN_DEFAULT: push_table();
                    FN_POWER_SAVE: begin
                        patched[7] = patched[7] | 32'h0010_0000;
                        push_table();
                    end
                    FN_ADC_GAIN: begin
                        if (c.arg_b > 8'd23) begin
                            push_word(ACT_REJECT, 3'd0, 32'd0, 8'd0, 1'b1);
                        end else begin
                            patched[4] = {patched[4][31:6], 1'b0, gain_code(c.arg_b)};
                            push_table();
                        end
                    end
                    FN_PGA_GAIN: begin
                        if (c.arg_a > 8'd9 || c.arg_b > 8'd9) begin
                            push_word(ACT_REJECT, 3'd0, 32'd0, 8'd0, 1'b1);
                        end else begin
                            top = gain_code(c.arg_a);
                            bot = gain_code(c.arg_b);
                            patched[2] = patched[2] | {20'd0, top, 7'd0} | {bot[2:0], 29'd0};
                            patched[3] = patched[3] | {30'd0, bot[4:3]};
                            push_table();
                        end
                    end
                    default: ;
                endcase
            end
            HDR_DATA: begin
                if (c.func == FN_IMAGE_DUMP)
                    push_word(ACT_IMAGE_DUMP, 3'd0, 32'd0, 8'd0, 1'b1);
                else if (c.func == FN_TEMPERATURE)
                    push_word(ACT_TEMPERATURE, 3'd0, 32'd0, 8'd0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function string describe(res_word_t r);
        return $sformatf("action %0d index %0d data %08h frames %0d last %0d",
                         r.action, r.word_index, r.word_data, r.frame_count, r.last);
    endfunction

    function void check_result(res_word_t got);
        res_word_t want;
        checked++;
        if (expected_results.size() == 0) begin
            errors++;
            if (errors <= report_limit)
                $display("ERROR: result word with nothing expected: %s", describe(got));
            return;
        end
        want = expected_results.pop_front();
        if (got.action !== want.action || got.word_index !== want.word_index ||
            got.word_data !== want.word_data || got.frame_count !== want.frame_count ||
            got.last !== want.last) begin
            errors++;
            if (errors <= report_limit) begin
                $display("ERROR: result word %0d mismatch", checked);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        end
    endfunction
endclass

module tb_sensor_command_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 16;     // covers a command still in flight with no result
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_CYCLES  = 400000;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_MIXED} fill_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    cmd_word_t   s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    res_word_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    decoder_scoreboard scoreboard = new();

    // Shared between the stimulus and the result sink
    bit          tx_steady      = 1'b0;   // sender offers words back to back
    int unsigned rx_hold        = 0;      // long stall requested from the result sink
    int unsigned cfg_writes     = 0;
    int unsigned table_settings = 0;

    sensor_command_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Observe every handshake on the edge it completes; pre-edge values only.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                scoreboard.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            if (s_valid && s_ready)
                scoreboard.note_command(s_data);
            if (m_valid && m_ready)
                scoreboard.check_result(m_data);
        end
    end

    // Result sink: draw a stall per word, switch to steady stretches now and then,
    // and honor a long hold when the stimulus asks for one.
    initial begin : result_sink
        int unsigned gap;
        bit          steady;
        steady = 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold != 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            if ($urandom_range(0, 31) == 0)
                steady = ~steady;
            gap = steady ? 0 : $urandom_range(0, 15);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // keep ready up until a word moves
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("ERROR: run did not finish within %0d cycles", LIMIT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic cmd_word_t frame(logic [7:0] header, logic [7:0] func,
                                        logic [7:0] arg_a, logic [7:0] arg_b,
                                        logic [7:0] byte_count);
        cmd_word_t c;
        c.header     = header;
        c.func       = func;
        c.arg_a      = arg_a;
        c.arg_b      = arg_b;
        c.byte_count = byte_count;
        return c;
    endfunction

    // Mostly well-formed frames with random content; a share of bad lengths,
    // unknown groups and scrambled sub-commands.
    function automatic cmd_word_t random_frame();
        cmd_word_t   c;
        int unsigned pick;
        c.arg_a = 8'($urandom_range(0, 255));
        c.arg_b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 11) == 0)
            c.byte_count = 8'($urandom_range(0, 255));
        else
            c.byte_count = FRAME_LEN;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            c.header = HDR_EXPOSURE;
            case ($urandom_range(0, 3))
                0:       c.func = FN_SET_FRAMES;
                1:       c.func = FN_SET_EXPOSURE;
                default: c.func = FN_START;
            endcase
        end else if (pick < 70) begin
            c.header = HDR_CONFIG;
            case ($urandom_range(0, 3))
                0:       c.func = FN_DEFAULT;
                1:       c.func = FN_POWER_SAVE;
                2:       c.func = FN_ADC_GAIN;
                default: c.func = FN_PGA_GAIN;
            endcase
            // keep most gain indexes legal so the table streams out
            if ($urandom_range(0, 4) != 0) begin
                c.arg_b = 8'($urandom_range(0, (c.func == FN_ADC_GAIN) ? 23 : 9));
                if (c.func == FN_PGA_GAIN)
                    c.arg_a = 8'($urandom_range(0, 9));
            end
        end else if (pick < 85) begin
            c.header = HDR_DATA;
            c.func   = $urandom_range(0, 1) ? FN_TEMPERATURE : FN_IMAGE_DUMP;
        end else begin
            c.header = 8'($urandom_range(0, 255));
            c.func   = 8'($urandom_range(0, 255));
        end
        if (pick < 85 && $urandom_range(0, 15) == 0)
            c.func = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Offer one command word. Valid stays up across back-to-back words and only
    // drops when a gap is drawn; the caller drops it at the end of a burst.
    task automatic send_cmd(input cmd_word_t c);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold a register write until it is taken; the caller drops valid after the last one.
    task automatic cfg_write(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        do @(posedge aclk); while (scoreboard.pending() != 0);
    endtask

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++) begin
            if (k % 32 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            send_cmd(random_frame());
        end
    endtask

    // Quiesce the block, then reprogram all eight table words.
    task automatic next_phase(input fill_t mode);
        logic [31:0] val;
        s_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            case (mode)
                FILL_ZERO:   val = '0;
                FILL_ONES:   val = '1;
                FILL_RANDOM: val = $urandom;
                default: begin
                    case ($urandom_range(0, 2))
                        0:       val = '0;
                        1:       val = '1;
                        default: val = $urandom;
                    endcase
                end
            endcase
            cfg_write(i[7:0], val);
        end
        if (mode == FILL_ZERO) begin
            // writes past the table must not alias onto a real word
            cfg_write(8'd8, $urandom);
            cfg_write(8'hFF, $urandom);
        end
        cfg_valid <= 1'b0;
        table_settings++;
    endtask

    initial begin : stimulus
        cmd_word_t directed [$];

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset state first: exposure start with frame count 1 and 2 ms
        directed.push_back(frame(HDR_EXPOSURE, FN_START, 8'h00, 8'h00, FRAME_LEN));
        // Extremes of frame count and exposure
        directed.push_back(frame(HDR_EXPOSURE, FN_SET_FRAMES, 8'hFF, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_EXPOSURE, FN_SET_EXPOSURE, 8'hFF, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_EXPOSURE, FN_START, 8'h5A, 8'hA5, FRAME_LEN));
        directed.push_back(frame(HDR_EXPOSURE, FN_SET_EXPOSURE, 8'h00, 8'hFF, FRAME_LEN));
        directed.push_back(frame(HDR_EXPOSURE, FN_SET_FRAMES, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_EXPOSURE, FN_START, 8'h00, 8'h00, FRAME_LEN));
        // Table commands on the reset table, gain limits and rejections
        directed.push_back(frame(HDR_CONFIG, FN_DEFAULT, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_POWER_SAVE, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_ADC_GAIN, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_ADC_GAIN, 8'hFF, 8'd23, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_ADC_GAIN, 8'h00, 8'd24, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_ADC_GAIN, 8'h00, 8'hFF, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_PGA_GAIN, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_PGA_GAIN, 8'd9, 8'd9, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_PGA_GAIN, 8'd10, 8'd0, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_PGA_GAIN, 8'd0, 8'd10, FRAME_LEN));
        directed.push_back(frame(HDR_CONFIG, FN_PGA_GAIN, 8'hFF, 8'hFF, FRAME_LEN));
        // Data requests
        directed.push_back(frame(HDR_DATA, FN_IMAGE_DUMP, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_DATA, FN_TEMPERATURE, 8'hFF, 8'hFF, FRAME_LEN));
        // Unknown sub-commands and groups: drop silently
        directed.push_back(frame(HDR_EXPOSURE, HDR_DATA, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(8'h00, FN_START, 8'h00, 8'h00, FRAME_LEN));
        directed.push_back(frame(HDR_DATA, 8'hFF, 8'h00, 8'h00, FRAME_LEN));
        // Wrong lengths: no result and no state change, then prove the frame count held
        directed.push_back(frame(HDR_EXPOSURE, FN_SET_FRAMES, 8'h77, 8'h00, 8'd5));
        directed.push_back(frame(HDR_CONFIG, FN_DEFAULT, 8'h00, 8'h00, 8'd0));
        directed.push_back(frame(HDR_EXPOSURE, FN_START, 8'h00, 8'h00, 8'hFF));
        directed.push_back(frame(HDR_EXPOSURE, FN_START, 8'h00, 8'h00, 8'd3));
        directed.push_back(frame(HDR_EXPOSURE, FN_START, 8'h00, 8'h00, FRAME_LEN));
        foreach (directed[i])
            send_cmd(directed[i]);

        // All-zero table, with stray writes past the table
        next_phase(FILL_ZERO);
        run_random(90);

        next_phase(FILL_ONES);
        run_random(80);

        // Stall the sink for a long stretch while table commands keep coming,
        // so the job and output registers fill and the input backs up.
        next_phase(FILL_RANDOM);
        rx_hold   = HOLD_CYCLES;
        tx_steady = 1'b1;
        for (int k = 0; k < 12; k++)
            send_cmd(frame(HDR_CONFIG, (k % 2 != 0) ? FN_POWER_SAVE : FN_DEFAULT,
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           FRAME_LEN));
        run_random(90);

        // Pause the sender until the block has delivered everything
        next_phase(FILL_MIXED);
        run_random(50);
        s_valid <= 1'b0;
        wait_drain();
        run_random(50);

        next_phase(FILL_MIXED);
        run_random(80);

        // Drain, then give stray results a chance to show up
        s_valid <= 1'b0;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Summary: %0d command words (%0d directed), %0d result words checked,",
                 scoreboard.commands, directed.size(), scoreboard.checked);
        $display("         %0d register writes over %0d reprogrammed tables, %0d errors.",
                 cfg_writes, table_settings, scoreboard.errors);
        if (scoreboard.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
